// ----- src/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers shared by the allocator RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/pfba_pkg.sv -----
// ============================================================================
// pfba_pkg
// Shared constants, codes and types of the per-frame bump allocator.
// ============================================================================
`timescale 1ns / 1ps

package pfba_pkg;

    localparam int MAX_FRAMES   = 4;
    localparam int OFFSET_WIDTH = 32;

    localparam int CAP_W      = 32;
    localparam int FCNT_W     = 3;
    localparam int IDX_W      = 2;
    localparam int SIZE_W     = 32;
    localparam int ALIGN_W    = 17;
    localparam int OUT_W      = 32;
    localparam int TOTAL_W    = 34;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Pointer width is the smaller of the offset and capacity widths.
    localparam int PTR_W  = (OFFSET_WIDTH < CAP_W) ? OFFSET_WIDTH : CAP_W;
    localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ACT_W  = $clog2(MAX_FRAMES + 1);
    localparam int END_W  = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 2;

    localparam logic [CAP_W-1:0]  CAPACITY_RESET    = CAP_W'(16777216);
    localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = FCNT_W'(3);

    localparam logic OP_NEW_FRAME = 1'b0;
    localparam logic OP_ALLOC     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OOM       = 2'd1,
        STATUS_BAD_FRAME = 2'd2
    } status_t;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [MAX_FRAMES-1:0][PTR_W-1:0] ptr_array_t;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   frame_index;
        logic [SIZE_W-1:0]  alloc_size;
        logic [ALIGN_W-1:0] alignment;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [OUT_W-1:0]   offset;
        logic [OUT_W-1:0]   granted_size;
        logic [OUT_W-1:0]   allocated_this_frame;
        logic [OUT_W-1:0]   remaining_this_frame;
        logic [TOTAL_W-1:0] allocated_all_frames;
    } rsp_t;

    // Allocator state as seen by the datapath.
    typedef struct packed {
        ptr_array_t         ptrs;
        logic [FIDX_W-1:0]  current;
        logic [TOTAL_W-1:0] total;
        ptr_t               cap_eff;
        logic [ACT_W-1:0]   active;
    } state_view_t;

    // State write-back produced by the datapath for one word.
    typedef struct packed {
        logic               ptr_we;
        logic [FIDX_W-1:0]  ptr_frame;
        ptr_t               ptr_value;
        logic [FIDX_W-1:0]  current;
        logic [TOTAL_W-1:0] total;
    } state_upd_t;

endpackage

// ----- src/pfba_in_if.sv -----
// ============================================================================
// pfba_in_if
// Request channel: valid/ready handshake with the allocator request fields.
// ============================================================================
`timescale 1ns / 1ps

interface pfba_in_if;

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [pfba_pkg::IDX_W-1:0]    frame_index;
    logic [pfba_pkg::SIZE_W-1:0]   alloc_size;
    logic [pfba_pkg::ALIGN_W-1:0]  alignment;

    modport source (
        output valid,
        output op,
        output frame_index,
        output alloc_size,
        output alignment,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  frame_index,
        input  alloc_size,
        input  alignment,
        output ready
    );

endinterface

// ----- src/pfba_out_if.sv -----
// ============================================================================
// pfba_out_if
// Result channel: valid/ready handshake with the allocator result fields.
// ============================================================================
`timescale 1ns / 1ps

interface pfba_out_if;

    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [pfba_pkg::OUT_W-1:0]    offset;
    logic [pfba_pkg::OUT_W-1:0]    granted_size;
    logic [pfba_pkg::OUT_W-1:0]    allocated_this_frame;
    logic [pfba_pkg::OUT_W-1:0]    remaining_this_frame;
    logic [pfba_pkg::TOTAL_W-1:0]  allocated_all_frames;

    modport source (
        output valid,
        output status,
        output offset,
        output granted_size,
        output allocated_this_frame,
        output remaining_this_frame,
        output allocated_all_frames,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  offset,
        input  granted_size,
        input  allocated_this_frame,
        input  remaining_this_frame,
        input  allocated_all_frames,
        output ready
    );

endinterface

// ----- src/pfba_in_reg.sv -----
// ============================================================================
// pfba_in_reg
// Input register that holds one request word until the datapath consumes it.
// ============================================================================
`timescale 1ns / 1ps

module pfba_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    pfba_in_if.sink         req,
    input  logic            advance,
    output pfba_pkg::req_t  item,
    output logic            item_valid
);

    logic            valid_reg;
    logic            valid_next;
    pfba_pkg::req_t  item_reg;
    pfba_pkg::req_t  item_next;
    logic            take;

    // The register frees up in the same cycle its word moves on.
    assign req.ready = !valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (take)
        begin
            valid_next            = 1'b1;
            item_next.op          = req.op;
            item_next.frame_index = req.frame_index;
            item_next.alloc_size  = req.alloc_size;
            item_next.alignment   = req.alignment;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// ----- src/pfba_state_regs.sv -----
// ============================================================================
// pfba_state_regs
// Configuration registers, per-frame bump pointers, current frame and total.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfba_state_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                advance,
    input  pfba_pkg::state_upd_t                upd,
    output pfba_pkg::state_view_t               st
);

    pfba_pkg::ptr_array_t                  ptrs_reg;
    pfba_pkg::ptr_array_t                  ptrs_next;
    logic [pfba_pkg::FIDX_W-1:0]           current_reg;
    logic [pfba_pkg::FIDX_W-1:0]           current_next;
    logic [pfba_pkg::TOTAL_W-1:0]          total_reg;
    logic [pfba_pkg::TOTAL_W-1:0]          total_next;
    logic [pfba_pkg::CAP_W-1:0]            capacity_reg;
    logic [pfba_pkg::CAP_W-1:0]            capacity_next;
    logic [pfba_pkg::FCNT_W-1:0]           frame_count_reg;
    logic [pfba_pkg::FCNT_W-1:0]           frame_count_next;
    logic [pfba_pkg::TOTAL_W-1:0]          ptr_sum;

    function automatic logic [pfba_pkg::ACT_W-1:0] active_frames(
        input logic [pfba_pkg::FCNT_W-1:0] fc
    );
        logic [pfba_pkg::ACT_W-1:0] n;
        if (fc == '0)
        begin
            n = pfba_pkg::ACT_W'(1);
        end
        else if (32'(fc) > pfba_pkg::MAX_FRAMES)
        begin
            n = pfba_pkg::ACT_W'(pfba_pkg::MAX_FRAMES);
        end
        else
        begin
            n = pfba_pkg::ACT_W'(fc);
        end
        return n;
    endfunction

    always_comb
    begin
        ptrs_next        = ptrs_reg;
        current_next     = current_reg;
        total_next       = total_reg;
        capacity_next    = capacity_reg;
        frame_count_next = frame_count_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pfba_pkg::CFG_CAPACITY:
                begin
                    capacity_next = cfg_wdata[pfba_pkg::CAP_W-1:0];
                end
                pfba_pkg::CFG_FRAME_COUNT:
                begin
                    // A new frame count restarts every frame.
                    frame_count_next = cfg_wdata[pfba_pkg::FCNT_W-1:0];
                    ptrs_next        = '0;
                    current_next     = '0;
                    total_next       = '0;
                end
                default:
                begin
                    capacity_next = capacity_reg;
                end
            endcase
        end
        else if (advance)
        begin
            if (upd.ptr_we)
            begin
                ptrs_next[upd.ptr_frame] = upd.ptr_value;
            end
            current_next = upd.current;
            total_next   = upd.total;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptrs_reg        <= '0;
            current_reg     <= '0;
            total_reg       <= '0;
            capacity_reg    <= pfba_pkg::CAPACITY_RESET;
            frame_count_reg <= pfba_pkg::FRAME_COUNT_RESET;
        end
        else
        begin
            ptrs_reg        <= ptrs_next;
            current_reg     <= current_next;
            total_reg       <= total_next;
            capacity_reg    <= capacity_next;
            frame_count_reg <= frame_count_next;
        end
    end

    assign st.ptrs    = ptrs_reg;
    assign st.current = current_reg;
    assign st.total   = total_reg;
    assign st.active  = active_frames(frame_count_reg);
    // The capacity saturates at the largest representable offset.
    assign st.cap_eff =
        (capacity_reg > pfba_pkg::CAP_W'({pfba_pkg::PTR_W{1'b1}})) ?
        {pfba_pkg::PTR_W{1'b1}} : pfba_pkg::PTR_W'(capacity_reg);

    always_comb
    begin
        ptr_sum = '0;
        for (int i = 0; i < pfba_pkg::MAX_FRAMES; i++)
        begin
            ptr_sum = ptr_sum + pfba_pkg::TOTAL_W'(ptrs_reg[i]);
        end
    end

    `ASSERT_IMPLIES(a_total_matches_ptrs, clk, rst_n, 1'b1, total_reg == ptr_sum)
    `ASSERT_IMPLIES(a_current_in_range, clk, rst_n, 1'b1, 32'(current_reg) < pfba_pkg::MAX_FRAMES)
    `ASSERT_NEXT(a_count_write_clears, clk, rst_n, cfg_we && cfg_index == pfba_pkg::CFG_FRAME_COUNT, total_reg == '0 && current_reg == '0)

endmodule

// ----- src/pfba_alloc_calc.sv -----
// ============================================================================
// pfba_alloc_calc
// Single-pass datapath: frame switch, alignment round-up, fit check and the
// state write-back and result word for one request.
// ============================================================================
`timescale 1ns / 1ps

module pfba_alloc_calc (
    input  pfba_pkg::req_t        req,
    input  pfba_pkg::state_view_t st,
    output pfba_pkg::state_upd_t  upd,
    output pfba_pkg::rsp_t        rsp
);

    // Mask of the bits below the highest set bit; zero alignment acts as one.
    function automatic logic [pfba_pkg::ALIGN_W-1:0] align_mask(
        input logic [pfba_pkg::ALIGN_W-1:0] align
    );
        logic [pfba_pkg::ALIGN_W-1:0] m;
        m = '0;
        for (int i = 0; i < pfba_pkg::ALIGN_W - 1; i++)
        begin
            m[i] = |(align >> (i + 1));
        end
        return m;
    endfunction

    logic [pfba_pkg::ALIGN_W-1:0]  mask;
    pfba_pkg::ptr_t                ptr_cur;
    pfba_pkg::ptr_t                ptr_after;
    logic [pfba_pkg::FIDX_W-1:0]   sel_frame;
    logic                          idx_ok;
    logic [pfba_pkg::END_W-1:0]    start_addr;
    logic [pfba_pkg::END_W-1:0]    end_addr;
    logic                          fits;
    pfba_pkg::ptr_t                remaining;

    always_comb
    begin
        mask      = align_mask(req.alignment);
        ptr_cur   = st.ptrs[st.current];
        sel_frame = pfba_pkg::FIDX_W'(req.frame_index);
        idx_ok    = 32'(req.frame_index) < 32'(st.active);

        start_addr = (pfba_pkg::END_W'(ptr_cur) + pfba_pkg::END_W'(mask))
                   & ~pfba_pkg::END_W'(mask);
        end_addr   = start_addr + pfba_pkg::END_W'(req.alloc_size);
        fits       = end_addr <= pfba_pkg::END_W'(st.cap_eff);

        upd.ptr_we    = 1'b0;
        upd.ptr_frame = st.current;
        upd.ptr_value = ptr_cur;
        upd.current   = st.current;
        upd.total     = st.total;

        rsp.status       = pfba_pkg::STATUS_OK;
        rsp.offset       = '0;
        rsp.granted_size = '0;
        ptr_after        = ptr_cur;

        case (req.op)
            pfba_pkg::OP_NEW_FRAME:
            begin
                if (idx_ok)
                begin
                    upd.ptr_we    = 1'b1;
                    upd.ptr_frame = sel_frame;
                    upd.ptr_value = '0;
                    upd.current   = sel_frame;
                    upd.total     = st.total - pfba_pkg::TOTAL_W'(st.ptrs[sel_frame]);
                    ptr_after     = '0;
                end
                else
                begin
                    rsp.status = pfba_pkg::STATUS_BAD_FRAME;
                end
            end
            pfba_pkg::OP_ALLOC:
            begin
                if (fits)
                begin
                    upd.ptr_we       = 1'b1;
                    upd.ptr_value    = pfba_pkg::PTR_W'(end_addr);
                    upd.total        = st.total - pfba_pkg::TOTAL_W'(ptr_cur)
                                     + pfba_pkg::TOTAL_W'(end_addr);
                    rsp.offset       = pfba_pkg::OUT_W'(start_addr);
                    rsp.granted_size = pfba_pkg::OUT_W'(req.alloc_size);
                    ptr_after        = pfba_pkg::PTR_W'(end_addr);
                end
                else
                begin
                    rsp.status = pfba_pkg::STATUS_OOM;
                end
            end
            default:
            begin
                rsp.status = pfba_pkg::STATUS_OK;
            end
        endcase

        // A pointer left above a lowered capacity reports nothing remaining.
        remaining = (st.cap_eff > ptr_after) ? st.cap_eff - ptr_after : '0;

        rsp.allocated_this_frame = pfba_pkg::OUT_W'(ptr_after);
        rsp.remaining_this_frame = pfba_pkg::OUT_W'(remaining);
        rsp.allocated_all_frames = upd.total;
    end

endmodule

// ----- src/per_frame_bump_allocator.sv -----
// ============================================================================
// per_frame_bump_allocator
// Flow: a request word goes through the input register, then the result
// register, which holds its result word while rsp.ready is low.
// Throughput: one request word per cycle while rsp.ready is high; the
// pointer update (align, add, compare on the current frame's pointer) is combinational.
// Reset: pointers, current frame and total clear at once; capacity resets
// to 16777216 and frame count to 3. No clearing pass is needed.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_frame_bump_allocator (
    input  logic                                clk,
    input  logic                                rst_n,
    pfba_in_if.sink                             req,
    pfba_out_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [pfba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfba_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    pfba_pkg::req_t         item;
    logic                   item_valid;
    logic                   advance;
    pfba_pkg::state_view_t  st;
    pfba_pkg::state_upd_t   upd;
    pfba_pkg::rsp_t         rsp_calc;
    pfba_pkg::rsp_t         rsp_reg;
    pfba_pkg::rsp_t         rsp_next;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;

    // A word moves to the result register when that register is free or drains.
    assign advance = item_valid && (!rsp_valid_reg || rsp.ready);

    pfba_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item       (item),
        .item_valid (item_valid)
    );

    pfba_state_regs u_state_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .upd       (upd),
        .st        (st)
    );

    pfba_alloc_calc u_alloc_calc (
        .req (item),
        .st  (st),
        .upd (upd),
        .rsp (rsp_calc)
    );

    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_next       = rsp_calc;
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp.valid                = rsp_valid_reg;
    assign rsp.status               = rsp_reg.status;
    assign rsp.offset               = rsp_reg.offset;
    assign rsp.granted_size         = rsp_reg.granted_size;
    assign rsp.allocated_this_frame = rsp_reg.allocated_this_frame;
    assign rsp.remaining_this_frame = rsp_reg.remaining_this_frame;
    assign rsp.allocated_all_frames = rsp_reg.allocated_all_frames;

    `ASSERT_NEXT(a_advance_loads_result, clk, rst_n, advance, rsp_valid_reg)
    `ASSERT_IMPLIES(a_failure_grants_nothing, clk, rst_n, rsp_valid_reg && rsp_reg.status != pfba_pkg::STATUS_OK, rsp_reg.granted_size == '0 && rsp_reg.offset == '0)
    `ASSERT_IMPLIES(a_ok_usage_adds_up, clk, rst_n, rsp_valid_reg && rsp_reg.status == pfba_pkg::STATUS_OK, (34'(rsp_reg.allocated_this_frame) + 34'(rsp_reg.remaining_this_frame)) == 34'(st.cap_eff))

endmodule
